### sv/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// shared types, round constants and helper functions of the sha-256 hasher
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned BLOCK_W     = 512;
	localparam int unsigned POS_W       = 6;
	localparam int unsigned ROUNDS      = 64;
	localparam int unsigned RND_W       = 7;
	localparam int unsigned LEN_W       = 64;

	localparam logic [7:0]       PAD_BYTE  = 8'h80;
	localparam logic [POS_W-1:0] LEN_POS   = 6'd56;
	localparam logic [POS_W-1:0] LAST_POS  = 6'd63;
	localparam logic [RND_W-1:0] FINAL_RND = 7'd64;
	localparam logic [2:0]       LAST_IDX  = 3'd7;

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// one queued input transaction
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       eom;
	} shs_item_t;

	// requests from the packer to the round engine
	typedef struct packed {
		logic start;
		logic init;
	} shs_eng_req_t;

	typedef logic [7:0][WORD_W-1:0] shs_hash_t;

	typedef enum logic [2:0] {
		P_DATA,
		P_MARK,
		P_ZERO,
		P_LEN,
		P_FLUSH,
		P_OUT
	} shs_pstate_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

`default_nettype wire

### sv/shs_front_fifo.sv
// ----------------------------------------------------------------------------
// shs_front_fifo
// input side: takes transactions, drops empty ones, queues the rest
// ----------------------------------------------------------------------------
`default_nettype none

module shs_front_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              byte_present,
	input  wire logic              end_of_message,
	output      logic              item_valid,
	input  wire logic              item_ready,
	output      shs_pkg::shs_item_t item
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	shs_pkg::shs_item_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign in_ready   = (count_q != CNT_FULL);
	// items without a byte and without an end mark change nothing
	assign push       = in_valid && in_ready && (byte_present || end_of_message);
	assign item_valid = (count_q != '0);
	assign pop        = item_valid && item_ready;
	assign item       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data: data_byte, present: byte_present, eom: end_of_message};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/shs_round_engine.sv
// ----------------------------------------------------------------------------
// shs_round_engine
// one sha-256 round per cycle over a 16-word rolling schedule, holds the
// chaining value
// ----------------------------------------------------------------------------
`default_nettype none

module shs_round_engine (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire shs_pkg::shs_eng_req_t           req,
	input  wire logic [shs_pkg::BLOCK_W-1:0]     block,
	output      logic                            busy,
	output      shs_pkg::shs_hash_t              digest
);

	logic [31:0] h_q  [8];
	logic [31:0] wv_q [8];
	logic [31:0] w_q  [16];
	logic [31:0] pre_q;
	logic [shs_pkg::RND_W-1:0] rnd_q;
	logic busy_q;

	logic [31:0] t1, t2, w_new;
	logic [shs_pkg::RND_W-1:0] rnd_next;
	logic rounds_on, finish;

	assign busy      = busy_q;
	assign rounds_on = busy_q && (rnd_q != shs_pkg::FINAL_RND);
	assign finish    = busy_q && (rnd_q == shs_pkg::FINAL_RND);
	assign rnd_next  = rnd_q + 1'b1;

	always_comb begin
		t1 = pre_q + shs_pkg::big_sig1(wv_q[4])
			+ ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]));
		t2 = shs_pkg::big_sig0(wv_q[0])
			+ ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
		w_new = shs_pkg::small_sig1(w_q[14]) + w_q[9]
			+ shs_pkg::small_sig0(w_q[1]) + w_q[0];
	end

	for (genvar i = 0; i < 8; i++) begin : g_digest
		assign digest[i] = h_q[i];
	end

	// schedule, working variables and the h + k + w term of the next round
	always_ff @(posedge clk) begin
		if (req.start) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= block[shs_pkg::BLOCK_W-1-32*i -: 32];
			end
			for (int i = 0; i < 8; i++) begin
				wv_q[i] <= h_q[i];
			end
			pre_q <= h_q[7] + shs_pkg::ROUND_K[0] + block[shs_pkg::BLOCK_W-1 -: 32];
		end else if (rounds_on) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
			pre_q   <= wv_q[6] + shs_pkg::ROUND_K[rnd_next[5:0]] + w_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= shs_pkg::INIT_HASH[i];
			end
		end else begin
			if (req.init) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= shs_pkg::INIT_HASH[i];
				end
			end else if (finish) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + wv_q[i];
				end
			end
			if (req.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
				rnd_q  <= '0;
			end else if (rounds_on) begin
				rnd_q <= rnd_next;
			end
		end
	end

endmodule

`default_nettype wire

### sv/shs_packer.sv
// ----------------------------------------------------------------------------
// shs_packer
// back side control: packs bytes into blocks, pads, hands blocks to the
// round engine and sends out the digest words
// ----------------------------------------------------------------------------
`default_nettype none

module shs_packer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output      logic                        item_ready,
	input  wire shs_pkg::shs_item_t          item,
	output      shs_pkg::shs_eng_req_t       req,
	output      logic [shs_pkg::BLOCK_W-1:0] block,
	input  wire logic                        busy,
	input  wire shs_pkg::shs_hash_t          digest,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [31:0]                 digest_word,
	output      logic [2:0]                  word_index,
	output      logic                        last_word
);

	shs_pkg::shs_pstate_t state_q, state_d;

	logic [shs_pkg::BLOCK_W-1:0] blk_q;
	logic [shs_pkg::POS_W-1:0]   pos_q;
	logic [shs_pkg::LEN_W-1:0]   cnt_q, cnt_next;
	logic [shs_pkg::LEN_W-1:0]   len_q;
	logic [2:0]                  idx_q;

	logic       can_shift, shift_en, take_item;
	logic [7:0] shift_byte;

	// a byte landing in the last slot needs the engine free
	assign can_shift = (pos_q != shs_pkg::LAST_POS) || !busy;
	assign take_item = item_valid && item_ready;
	assign cnt_next  = cnt_q + {{(shs_pkg::LEN_W-1){1'b0}}, item.present};
	assign block     = {blk_q[shs_pkg::BLOCK_W-9:0], shift_byte};

	assign digest_word = digest[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == shs_pkg::LAST_IDX);

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		shift_en   = 1'b0;
		shift_byte = 8'h00;
		out_valid  = 1'b0;
		req.init   = 1'b0;
		unique case (state_q)
			shs_pkg::P_DATA: begin
				item_ready = can_shift;
				if (item_valid && can_shift) begin
					shift_en   = item.present;
					shift_byte = item.data;
					if (item.eom) begin
						state_d = shs_pkg::P_MARK;
					end
				end
			end
			shs_pkg::P_MARK: begin
				if (can_shift) begin
					shift_en   = 1'b1;
					shift_byte = shs_pkg::PAD_BYTE;
					state_d    = (pos_q == shs_pkg::LEN_POS - 1'b1) ? shs_pkg::P_LEN
						: shs_pkg::P_ZERO;
				end
			end
			shs_pkg::P_ZERO: begin
				if (can_shift) begin
					shift_en = 1'b1;
					if (pos_q == shs_pkg::LEN_POS - 1'b1) begin
						state_d = shs_pkg::P_LEN;
					end
				end
			end
			shs_pkg::P_LEN: begin
				if (can_shift) begin
					shift_en   = 1'b1;
					shift_byte = len_q[shs_pkg::LEN_W-1 -: 8];
					if (pos_q == shs_pkg::LAST_POS) begin
						state_d = shs_pkg::P_FLUSH;
					end
				end
			end
			shs_pkg::P_FLUSH: begin
				if (!busy) begin
					state_d = shs_pkg::P_OUT;
				end
			end
			shs_pkg::P_OUT: begin
				out_valid = 1'b1;
				if (out_ready && last_word) begin
					req.init = 1'b1;
					state_d  = shs_pkg::P_DATA;
				end
			end
			default: begin
				state_d = shs_pkg::P_DATA;
			end
		endcase
		req.start = shift_en && (pos_q == shs_pkg::LAST_POS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shs_pkg::P_DATA;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= block;
		end
		if (take_item && item.eom) begin
			len_q <= {cnt_next[shs_pkg::LEN_W-4:0], 3'b000};
		end else if (shift_en && state_q == shs_pkg::P_LEN) begin
			len_q <= {len_q[shs_pkg::LEN_W-9:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (shift_en) begin
				pos_q <= pos_q + 1'b1;
			end
			if (req.init) begin
				cnt_q <= '0;
			end else if (take_item) begin
				cnt_q <= cnt_next;
			end
			if (out_valid && out_ready) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// digest words only come from a settled chaining value
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !busy)
		else $error("digest shown while engine busy");

	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy && pos_q == shs_pkg::LAST_POS)
		else $error("block start while engine busy");

	a_no_take_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != shs_pkg::P_DATA) |-> !item_ready)
		else $error("queue drained outside data phase");

	a_init_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		req.init |=> (idx_q == 3'd0) && (pos_q == '0))
		else $error("message state not cleared after digest");

endmodule

`default_nettype wire

### sv/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// streaming sha-256: one message byte per input transaction, eight digest
// words out per message
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready with data_byte, byte_present and
//   end_of_message. a transaction with neither flag set is taken and dropped.
//   transactions land in a QUEUE_DEPTH entry queue; until it is full the
//   input flows while the back end pads, compresses or drains the digest.
// output channel: out_valid/out_ready with digest_word, word_index and
//   last_word; eight transactions per message, word 0 first.
// throughput: about one byte per cycle while filling a block, unless the
//   byte for the last slot waits on a busy engine; the 64-round engine
//   works on block n while block n+1 fills, so the round loop is the limit.
// after the end-of-message transaction leaves the queue, the padding
//   bytes fill the block up to its end, then the last compression runs
//   (after the block before, when that is still in the engine) and the
//   digest is handed to the output, then the digest words go out, one per
//   accepted output cycle.
// a stalled output holds the digest steady; the back end takes nothing from
//   the queue until word 7 is accepted, then reloads the initial hash.
// reset: asynchronous, active low; clears the queue, the byte count and the
//   message state and loads the standard initial hash words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_message,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [31:0] digest_word,
	output      logic [2:0]  word_index,
	output      logic        last_word
);

	// queue to back end
	logic               item_valid;
	logic               item_ready;
	shs_pkg::shs_item_t item;

	// packer to round engine
	shs_pkg::shs_eng_req_t       eng_req;
	logic [shs_pkg::BLOCK_W-1:0] eng_block;
	logic                        eng_busy;
	shs_pkg::shs_hash_t          eng_digest;

	// front: accept, drop empty transactions, queue
	shs_front_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.item           (item)
	);

	// back: block packing, padding, length and digest sequencing
	shs_packer u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.req         (eng_req),
		.block       (eng_block),
		.busy        (eng_busy),
		.digest      (eng_digest),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	// back: compression rounds and chaining value
	shs_round_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (eng_req),
		.block  (eng_block),
		.busy   (eng_busy),
		.digest (eng_digest)
	);

endmodule

`default_nettype wire
